>>> sv/pva_pkg.sv
// Types and codes shared by the primitive vertex assembler.
// No dependencies; every other file of the block imports this package.
package pva_pkg;

	localparam logic [1:0] FUNC_SET_KIND  = 2'd0;
	localparam logic [1:0] FUNC_SET_COLOR = 2'd1;
	localparam logic [1:0] FUNC_SET_TEX   = 2'd2;
	localparam logic [1:0] FUNC_KICK      = 2'd3;

	localparam logic [2:0] KIND_TRI_STRIP = 3'd4;
	localparam logic [2:0] KIND_SPRITE    = 3'd6;

	localparam logic [1:0] OP_ERROR  = 2'd0;
	localparam logic [1:0] OP_SPRITE = 2'd1;
	localparam logic [1:0] OP_STRIP  = 2'd2;

	localparam logic [2:0] BEAT_STRIP_LAST  = 3'd2;
	localparam logic [2:0] BEAT_SPRITE_LAST = 3'd5;
	localparam logic [1:0] STRIP_FULL       = 2'd3;

	typedef struct packed {
		logic [1:0]  func;
		logic [2:0]  prim_kind;
		logic [31:0] color;
		logic [31:0] tex_s;
		logic [31:0] tex_t;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [23:0] pos_z;
	} in_t;

	typedef struct packed {
		logic [31:0] out_x;
		logic [31:0] out_y;
		logic [23:0] out_z;
		logic [31:0] out_color;
		logic [31:0] out_s;
		logic [31:0] out_t;
		logic        last;
		logic        error;
	} out_t;

	typedef struct packed {
		logic [15:0] x;
		logic [15:0] y;
		logic [23:0] z;
		logic [31:0] color;
		logic [31:0] s;
		logic [31:0] t;
	} slot_t;

	typedef struct packed {
		logic [1:0]       op;
		slot_t [2:0]      slots;
	} job_t;

	typedef struct packed {
		logic valid;
		logic pop;
	} q_ctrl_t;

endpackage

>>> sv/pva_front.sv
// Front end of the assembler: accepts input beats, keeps the vertex slots and
// current attributes, and pushes jobs for the back end into the queue. Uses pva_pkg.
module pva_front (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         item_valid,
	output logic         item_stall,
	input  pva_pkg::in_t item,
	output logic         push_valid,
	output pva_pkg::job_t push_job,
	input  logic         push_full
);
	import pva_pkg::*;

	slot_t [2:0] slots_q, slots_d;
	logic [31:0] color_q, color_d;
	logic [63:0] tex_q, tex_d;
	logic [1:0]  fill_q, fill_d;
	logic [1:0]  strip_q, strip_d;
	logic [2:0]  kind_q, kind_d;
	logic [1:0]  idx;
	logic        has_job;
	logic        accept;
	slot_t       new_slot;

	assign item_stall = push_full;
	assign accept     = item_valid && !push_full;
	assign push_valid = accept && has_job;

	always_comb begin
		slots_d  = slots_q;
		color_d  = color_q;
		tex_d    = tex_q;
		fill_d   = fill_q;
		strip_d  = strip_q;
		kind_d   = kind_q;
		has_job  = 1'b0;
		push_job.op = OP_ERROR;
		idx      = 2'd0;
		new_slot.x     = item.pos_x;
		new_slot.y     = item.pos_y;
		new_slot.z     = item.pos_z;
		new_slot.color = color_q;
		new_slot.s     = tex_q[31:0];
		new_slot.t     = tex_q[63:32];
		case (item.func)
			FUNC_SET_KIND: begin
				if (strip_q != 2'd0) begin
					strip_d = 2'd0;
					fill_d  = 2'd0;
				end else if (fill_q != 2'd0) begin
					fill_d  = 2'd0;
					has_job = 1'b1;
				end
				kind_d = item.prim_kind;
			end
			FUNC_SET_COLOR: begin
				color_d = item.color;
			end
			FUNC_SET_TEX: begin
				tex_d = {item.tex_t, item.tex_s};
			end
			default: begin
				if (kind_q == KIND_SPRITE) begin
					idx = (fill_q >= 2'd2) ? 2'd0 : fill_q;
					for (int i = 0; i < 3; i++) begin
						if (idx == 2'(i)) slots_d[i] = new_slot;
					end
					if (idx == 2'd1) begin
						fill_d      = 2'd0;
						has_job     = 1'b1;
						push_job.op = OP_SPRITE;
					end else begin
						fill_d = idx + 2'd1;
					end
				end else if (kind_q == KIND_TRI_STRIP) begin
					idx = (fill_q == 2'd3) ? 2'd0 : fill_q;
					for (int i = 0; i < 3; i++) begin
						if (idx == 2'(i)) slots_d[i] = new_slot;
					end
					fill_d  = (idx == 2'd2) ? 2'd0 : idx + 2'd1;
					strip_d = (strip_q == STRIP_FULL) ? STRIP_FULL : strip_q + 2'd1;
					if (strip_d == STRIP_FULL) begin
						has_job     = 1'b1;
						push_job.op = OP_STRIP;
					end
				end else begin
					has_job = 1'b1;
				end
			end
		endcase
		push_job.slots = slots_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_q <= '0;
			color_q <= '0;
			tex_q   <= '0;
			fill_q  <= '0;
			strip_q <= '0;
			kind_q  <= '0;
		end else if (accept) begin
			slots_q <= slots_d;
			color_q <= color_d;
			tex_q   <= tex_d;
			fill_q  <= fill_d;
			strip_q <= strip_d;
			kind_q  <= kind_d;
		end
	end

endmodule

>>> sv/pva_queue.sv
// Short job queue between the front and back ends of the assembler.
// Uses pva_pkg for the job type.
module pva_queue #(
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	input  pva_pkg::job_t    push_job,
	output logic             full,
	output pva_pkg::q_ctrl_t ctrl_out,
	input  logic             pop,
	output pva_pkg::job_t    head
);
	import pva_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t              entries_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_pop;

	assign full           = (count_q == CNT_W'(DEPTH));
	assign ctrl_out.valid = (count_q != '0);
	assign ctrl_out.pop   = do_pop;
	assign do_pop         = pop && (count_q != '0);
	assign head           = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_valid) begin
			entries_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_valid) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push_valid && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push_valid) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push_valid |-> !full)
		else $error("Job pushed into a full queue.");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("Queue count exceeds its depth.");

endmodule

>>> sv/pva_back.sv
// Back end of the assembler: expands each queued job into result beats, one
// per cycle while result_stall is low, through a registered output stage. Uses pva_pkg.
module pva_back (
	input  logic             clk,
	input  logic             arst_n,
	input  pva_pkg::q_ctrl_t q_ctrl,
	input  pva_pkg::job_t    job,
	output logic             pop,
	output logic             result_valid,
	input  logic             result_stall,
	output pva_pkg::out_t    result
);
	import pva_pkg::*;

	logic [2:0] beat_q;
	logic       out_valid_q;
	out_t       out_q;
	out_t       nxt;
	logic       load;
	logic       final_beat;
	slot_t      sel;

	assign load         = !out_valid_q || !result_stall;
	assign pop          = load && q_ctrl.valid && final_beat;
	assign result_valid = out_valid_q;
	assign result       = out_q;

	always_comb begin
		nxt        = '0;
		final_beat = 1'b1;
		case (beat_q)
			3'd0:    sel = job.slots[0];
			3'd1:    sel = job.slots[1];
			default: sel = job.slots[2];
		endcase
		case (job.op)
			OP_STRIP: begin
				final_beat    = (beat_q == BEAT_STRIP_LAST);
				nxt.out_x     = {sel.x, 16'h0000};
				nxt.out_y     = {sel.y, 16'h0000};
				nxt.out_z     = sel.z;
				nxt.out_color = sel.color;
				nxt.out_s     = sel.s;
				nxt.out_t     = sel.t;
				nxt.last      = final_beat;
			end
			OP_SPRITE: begin
				final_beat = (beat_q == BEAT_SPRITE_LAST);
				nxt.out_x  = (beat_q == 3'd2 || beat_q == 3'd3 || beat_q == 3'd4) ?
					{job.slots[1].x, 16'h0000} : {job.slots[0].x, 16'h0000};
				nxt.out_y  = (beat_q == 3'd0 || beat_q == 3'd4 || beat_q == 3'd5) ?
					{job.slots[0].y, 16'h0000} : {job.slots[1].y, 16'h0000};
				if (beat_q == 3'd0 || beat_q == 3'd5) begin
					nxt.out_z     = job.slots[0].z;
					nxt.out_color = job.slots[0].color;
				end else begin
					nxt.out_z     = job.slots[1].z;
					nxt.out_color = job.slots[1].color;
				end
				nxt.last = final_beat;
			end
			default: begin
				nxt.last  = 1'b1;
				nxt.error = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load && q_ctrl.valid) begin
			out_q <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			beat_q      <= '0;
		end else if (load) begin
			out_valid_q <= q_ctrl.valid;
			if (q_ctrl.valid) begin
				beat_q <= final_beat ? 3'd0 : beat_q + 3'd1;
			end
		end
	end

	a_beat_needs_job: assert property (@(posedge clk) disable iff (!arst_n)
		beat_q != 3'd0 |-> q_ctrl.valid)
		else $error("Beat counter running without a queued job.");

	a_error_single: assert property (@(posedge clk) disable iff (!arst_n)
		(q_ctrl.valid && job.op != OP_SPRITE && job.op != OP_STRIP) |-> beat_q == 3'd0)
		else $error("Error job expanded into more than one beat.");

	a_pop_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		q_ctrl.pop |=> (out_valid_q && out_q.last))
		else $error("Job retired without a final result beat.");

endmodule

>>> sv/primitive_vertex_assembler_core.sv
// Top level of the primitive vertex assembler: front end, job queue, back end.
// Depends on pva_pkg, pva_front, pva_queue and pva_back.
//
// Channel   Direction  Payload           Handshake
// item      in         pva_pkg::in_t     item_valid / item_stall
// result    out        pva_pkg::out_t    result_valid / result_stall
//
// Set-kind, set-colour and set-texcoord items are handled in the front end.
// A strip vertex yields three result beats and a sprite pair six, one beat per
// cycle while result_stall is low, from the back end's single output register.
// Reset clears all slots and current attributes; the block is ready at once.
// item_stall rises when the job queue is full; the front and back stall independently.
module primitive_vertex_assembler_core #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_stall,
	input  pva_pkg::in_t  item,
	output logic          result_valid,
	input  logic          result_stall,
	output pva_pkg::out_t result
);
	import pva_pkg::*;

	logic    push_valid;
	job_t    push_job;
	logic    q_full;
	q_ctrl_t q_ctrl;
	logic    q_pop;
	job_t    q_head;

	pva_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.push_valid (push_valid),
		.push_job   (push_job),
		.push_full  (q_full)
	);

	pva_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_job   (push_job),
		.full       (q_full),
		.ctrl_out   (q_ctrl),
		.pop        (q_pop),
		.head       (q_head)
	);

	pva_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_ctrl       (q_ctrl),
		.job          (q_head),
		.pop          (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
